// ===== rtl/core/pcvc_pkg.sv =====
// Shared types, constants and helpers for the peak-centred viewport crop.
`default_nettype none
package pcvc_pkg;

	localparam int REG_W     = 13;
	localparam int DIM_W     = 12;
	localparam int ACT_W     = 32;
	localparam int PIX_W     = 16;
	localparam int IDX_W     = 3;
	localparam logic [REG_W-1:0] MAX_DIM = 13'd4096;

	// Pixel queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Corner unit: numerator 2*pos*span + size fits in 25 bits
	localparam int NUM_W  = 25;
	localparam int PROD_W = 2 * DIM_W;
	localparam int REM_W  = REG_W + 1;
	localparam int CNT_W  = 5;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_VIEW_WIDTH      = 3'd2,
		REG_VIEW_HEIGHT     = 3'd3,
		REG_MAP_WIDTH       = 3'd4,
		REG_MAP_HEIGHT      = 3'd5,
		REG_CENTER_FROM_MAP = 3'd6
	} reg_index_t;

	// Dimensions already clamped to 1..MAX_DIM
	typedef struct packed {
		logic [REG_W-1:0] image_width;
		logic [REG_W-1:0] image_height;
		logic [REG_W-1:0] view_width;
		logic [REG_W-1:0] view_height;
		logic [REG_W-1:0] map_width;
		logic [REG_W-1:0] map_height;
		logic             center_from_map;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             first;
		logic [DIM_W-1:0] best_col;
		logic [DIM_W-1:0] best_row;
	} pix_entry_t;

	typedef struct packed {
		logic             start;
		logic [DIM_W-1:0] pos;
		logic [DIM_W-1:0] span;
		logic [REG_W-1:0] size;
	} corner_req_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] quot;
	} corner_rsp_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_CALC_X,
		BK_CALC_Y
	} back_state_t;

	typedef enum logic [1:0] {
		CN_IDLE,
		CN_MUL,
		CN_DIV
	} corner_state_t;

	// Zero counts as one, anything above MAX_DIM counts as MAX_DIM
	function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] r);
		logic [REG_W-1:0] v;
		if (r == '0) begin
			v = {{(REG_W-1){1'b0}}, 1'b1};
		end else if (r > MAX_DIM) begin
			v = MAX_DIM;
		end else begin
			v = r;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pcvc_queue.sv =====
// Short pixel queue that decouples the front from the back.
`default_nettype none
module pcvc_queue
	import pcvc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  pix_entry_t      wr_data,
	input  wire logic       rd_en,
	output pix_entry_t      rd_data,
	output logic            full,
	output logic            empty
);

	pix_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store on write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pcvc_front.sv =====
// Front end: tracks the map peak and numbers the image pixels.
`default_nettype none
module pcvc_front
	import pcvc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  cfg_t                         cfg,
	input  wire logic                    take,
	input  wire logic                    func,
	input  wire logic signed [ACT_W-1:0] activation,
	input  wire logic [PIX_W-1:0]        pixel,
	output logic                         q_push,
	output pix_entry_t                   q_entry
);

	logic signed [ACT_W-1:0] best_value_q;
	logic [DIM_W-1:0]        best_col_q;
	logic [DIM_W-1:0]        best_row_q;
	logic [DIM_W-1:0]        map_col_q;
	logic [DIM_W-1:0]        map_row_q;
	logic [DIM_W-1:0]        img_col_q;
	logic [DIM_W-1:0]        img_row_q;

	logic map_first;
	logic map_better;
	logic map_col_wrap;
	logic map_row_wrap;
	logic img_first;
	logic img_col_wrap;
	logic img_row_wrap;

	assign map_first    = (map_col_q == '0) && (map_row_q == '0);
	assign map_better   = activation > best_value_q;
	assign map_col_wrap = ({1'b0, map_col_q} + 13'd1) >= cfg.map_width;
	assign map_row_wrap = ({1'b0, map_row_q} + 13'd1) >= cfg.map_height;
	assign img_first    = (img_col_q == '0) && (img_row_q == '0);
	assign img_col_wrap = ({1'b0, img_col_q} + 13'd1) >= cfg.image_width;
	assign img_row_wrap = ({1'b0, img_row_q} + 13'd1) >= cfg.image_height;

	// Hand pixels to the back with the peak as it stands now
	assign q_push           = take && func;
	assign q_entry.pixel    = pixel;
	assign q_entry.col      = img_col_q;
	assign q_entry.row      = img_row_q;
	assign q_entry.first    = img_first;
	assign q_entry.best_col = best_col_q;
	assign q_entry.best_row = best_row_q;

	// Peak search and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q <= '0;
			best_col_q   <= '0;
			best_row_q   <= '0;
			map_col_q    <= '0;
			map_row_q    <= '0;
			img_col_q    <= '0;
			img_row_q    <= '0;
		end else if (take && !func) begin
			if (map_first || map_better) begin
				best_value_q <= activation;
				best_col_q   <= map_col_q;
				best_row_q   <= map_row_q;
			end
			if (map_col_wrap) begin
				map_col_q <= '0;
				map_row_q <= map_row_wrap ? '0 : map_row_q + 1'b1;
			end else begin
				map_col_q <= map_col_q + 1'b1;
			end
		end else if (take && func) begin
			if (img_col_wrap) begin
				img_col_q <= '0;
				if (img_row_wrap) begin
					// end of image: restart the map of the next frame
					img_row_q <= '0;
					map_col_q <= '0;
					map_row_q <= '0;
				end else begin
					img_row_q <= img_row_q + 1'b1;
				end
			end else begin
				img_col_q <= img_col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pcvc_corner.sv =====
// Corner unit: round(pos * span / size), half up, saturated to span.
`default_nettype none
module pcvc_corner
	import pcvc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  corner_req_t req,
	output corner_rsp_t rsp
);

	corner_state_t     state_q;
	corner_state_t     state_d;
	logic [DIM_W-1:0]  pos_q;
	logic [DIM_W-1:0]  span_q;
	logic [REG_W-1:0]  size_q;
	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIM_W-1:0]  result_q;

	logic [PROD_W-1:0] prod;
	logic [REM_W:0]    rem_sh;
	logic [REM_W:0]    divisor;
	logic              rem_ge;
	logic [REM_W:0]    rem_next;
	logic [NUM_W-1:0]  quot_next;

	assign prod      = pos_q * span_q;
	assign rem_sh    = {rem_q, num_q[NUM_W-1]};
	assign divisor   = {1'b0, size_q, 1'b0};
	assign rem_ge    = rem_sh >= divisor;
	assign rem_next  = rem_ge ? rem_sh - divisor : rem_sh;
	assign quot_next = {quot_q[NUM_W-2:0], rem_ge};

	assign rsp.done = done_q;
	assign rsp.quot = result_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CN_IDLE: begin
				if (req.start) begin
					state_d = CN_MUL;
				end
			end
			CN_MUL: begin
				state_d = CN_DIV;
			end
			CN_DIV: begin
				if (cnt_q == '0) begin
					state_d = CN_IDLE;
				end
			end
			default: begin
				state_d = CN_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CN_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == CN_DIV) && (cnt_q == '0);
		end
	end

	// Multiply once, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			CN_IDLE: begin
				if (req.start) begin
					pos_q  <= req.pos;
					span_q <= req.span;
					size_q <= req.size;
				end
			end
			CN_MUL: begin
				num_q  <= {prod, 1'b0} + NUM_W'(size_q);
				rem_q  <= '0;
				quot_q <= '0;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end
			CN_DIV: begin
				rem_q  <= rem_next[REM_W-1:0];
				quot_q <= quot_next;
				num_q  <= {num_q[NUM_W-2:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					result_q <= (quot_next > NUM_W'(span_q)) ? span_q
						: quot_next[DIM_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/pcvc_back.sv =====
// Back end: fixes the window corner per frame and crops the pixels.
`default_nettype none
module pcvc_back
	import pcvc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cfg_t             cfg,
	input  wire logic        q_empty,
	input  pix_entry_t       q_head,
	output logic             q_pop,
	output corner_req_t      corner_req,
	input  corner_rsp_t      corner_rsp,
	input  wire logic        pop,
	output logic             empty,
	output logic [PIX_W-1:0] pixel_out,
	output logic [DIM_W-1:0] out_col,
	output logic [DIM_W-1:0] out_row,
	output logic             last,
	output logic             size_error
);

	back_state_t      state_q;
	back_state_t      state_d;
	logic [DIM_W-1:0] left_q;
	logic [DIM_W-1:0] top_q;
	logic             drop_q;
	logic             corner_done_q;
	logic             out_valid_q;

	logic [REG_W-1:0] span_x;
	logic [REG_W-1:0] span_y;
	logic [REG_W-1:0] half_x;
	logic [REG_W-1:0] half_y;
	logic             size_bad;
	logic             need_corner;
	logic             slot_free;
	logic [DIM_W-1:0] off_col;
	logic [DIM_W-1:0] off_row;
	logic             in_window;
	logic             hit;
	logic             load_err;
	logic             load_pix;
	logic             set_centre;
	logic             take_x;
	logic             take_y;

	assign size_bad    = (cfg.view_width > cfg.image_width)
		|| (cfg.view_height > cfg.image_height);
	assign span_x      = cfg.image_width - cfg.view_width;
	assign span_y      = cfg.image_height - cfg.view_height;
	assign half_x      = (span_x + 13'd1) >> 1;
	assign half_y      = (span_y + 13'd1) >> 1;
	assign need_corner = !q_empty && q_head.first && !corner_done_q;
	assign slot_free   = !out_valid_q || pop;
	assign off_col     = q_head.col - left_q;
	assign off_row     = q_head.row - top_q;
	assign in_window   = (q_head.col >= left_q) && ({1'b0, off_col} < cfg.view_width)
		&& (q_head.row >= top_q) && ({1'b0, off_row} < cfg.view_height);
	assign hit         = !drop_q && in_window;
	assign empty       = !out_valid_q;

	// Sequence the corner, then crop one pixel per cycle unless stalled
	always_comb begin
		state_d         = state_q;
		q_pop           = 1'b0;
		load_err        = 1'b0;
		load_pix        = 1'b0;
		set_centre      = 1'b0;
		take_x          = 1'b0;
		take_y          = 1'b0;
		corner_req      = '0;
		corner_req.pos  = q_head.best_col;
		corner_req.span = span_x[DIM_W-1:0];
		corner_req.size = cfg.map_width;
		unique case (state_q)
			BK_RUN: begin
				if (need_corner) begin
					if (size_bad) begin
						if (slot_free) begin
							load_err = 1'b1;
							q_pop    = 1'b1;
						end
					end else if (cfg.center_from_map) begin
						corner_req.start = 1'b1;
						state_d          = BK_CALC_X;
					end else begin
						set_centre = 1'b1;
					end
				end else if (!q_empty && slot_free) begin
					q_pop    = 1'b1;
					load_pix = hit;
				end
			end
			BK_CALC_X: begin
				if (corner_rsp.done) begin
					take_x           = 1'b1;
					corner_req.start = 1'b1;
					corner_req.pos   = q_head.best_row;
					corner_req.span  = span_y[DIM_W-1:0];
					corner_req.size  = cfg.map_height;
					state_d          = BK_CALC_Y;
				end
			end
			BK_CALC_Y: begin
				if (corner_rsp.done) begin
					take_y  = 1'b1;
					state_d = BK_RUN;
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_RUN;
			left_q        <= '0;
			top_q         <= '0;
			drop_q        <= 1'b0;
			corner_done_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_centre) begin
				left_q        <= half_x[DIM_W-1:0];
				top_q         <= half_y[DIM_W-1:0];
				drop_q        <= 1'b0;
				corner_done_q <= 1'b1;
			end
			if (take_x) begin
				left_q <= corner_rsp.quot;
			end
			if (take_y) begin
				top_q         <= corner_rsp.quot;
				drop_q        <= 1'b0;
				corner_done_q <= 1'b1;
			end
			if (load_err) begin
				drop_q <= 1'b1;
			end
			if (q_pop) begin
				corner_done_q <= 1'b0;
			end
			if (load_err || load_pix) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_err) begin
			pixel_out  <= '0;
			out_col    <= '0;
			out_row    <= '0;
			last       <= 1'b0;
			size_error <= 1'b1;
		end else if (load_pix) begin
			pixel_out  <= q_head.pixel;
			out_col    <= off_col;
			out_row    <= off_row;
			last       <= ({1'b0, off_col} == cfg.view_width - 13'd1)
				&& ({1'b0, off_row} == cfg.view_height - 13'd1);
			size_error <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/peak_centered_viewport_crop.sv =====
// Top level of the peak-centred viewport crop: registers and wiring.
//
// Each frame is an activation map followed by an image, both row-major, on
// one input queue (func 0 for a map sample, 1 for a pixel). Map samples and
// ordinary pixels are taken one per cycle while the queue is not full. The
// first pixel of each frame fixes the window corner in the back end.
// Centring on the map peak runs the shared multiply and bit-serial divide
// unit twice. Meanwhile the front keeps accepting until the four-entry pixel
// queue fills. Pixels inside the window leave one per cycle, while pop keeps
// up, through a single result register. A view larger than the image gives
// one result with size_error set, and the rest of that frame is dropped.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
module peak_centered_viewport_crop
	import pcvc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [IDX_W-1:0]        cfg_index,
	input  wire logic [REG_W-1:0]        cfg_data,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic                    func,
	input  wire logic signed [ACT_W-1:0] activation,
	input  wire logic [PIX_W-1:0]        pixel,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [PIX_W-1:0]             pixel_out,
	output logic [DIM_W-1:0]             out_col,
	output logic [DIM_W-1:0]             out_row,
	output logic                         last,
	output logic                         size_error
);

	logic [REG_W-1:0] image_width_q;
	logic [REG_W-1:0] image_height_q;
	logic [REG_W-1:0] view_width_q;
	logic [REG_W-1:0] view_height_q;
	logic [REG_W-1:0] map_width_q;
	logic [REG_W-1:0] map_height_q;
	logic             center_from_map_q;

	cfg_t        cfg;
	logic        take;
	logic        q_push;
	pix_entry_t  q_entry;
	logic        q_pop;
	pix_entry_t  q_head;
	logic        q_full;
	logic        q_empty;
	corner_req_t corner_req;
	corner_rsp_t corner_rsp;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= 13'd640;
			image_height_q    <= 13'd480;
			view_width_q      <= 13'd10;
			view_height_q     <= 13'd10;
			map_width_q       <= 13'd64;
			map_height_q      <= 13'd64;
			center_from_map_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:     image_width_q     <= cfg_data;
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data;
				REG_VIEW_WIDTH:      view_width_q      <= cfg_data;
				REG_VIEW_HEIGHT:     view_height_q     <= cfg_data;
				REG_MAP_WIDTH:       map_width_q       <= cfg_data;
				REG_MAP_HEIGHT:      map_height_q      <= cfg_data;
				REG_CENTER_FROM_MAP: center_from_map_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the dimensions once for both halves
	assign cfg.image_width     = clamp_dim(image_width_q);
	assign cfg.image_height    = clamp_dim(image_height_q);
	assign cfg.view_width      = clamp_dim(view_width_q);
	assign cfg.view_height     = clamp_dim(view_height_q);
	assign cfg.map_width       = clamp_dim(map_width_q);
	assign cfg.map_height      = clamp_dim(map_height_q);
	assign cfg.center_from_map = center_from_map_q;

	assign full = q_full;
	assign take = push && !q_full;

	pcvc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.take       (take),
		.func       (func),
		.activation (activation),
		.pixel      (pixel),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	pcvc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_entry),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	pcvc_corner u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (corner_req),
		.rsp    (corner_rsp)
	);

	pcvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.corner_req (corner_req),
		.corner_rsp (corner_rsp),
		.pop        (pop),
		.empty      (empty),
		.pixel_out  (pixel_out),
		.out_col    (out_col),
		.out_row    (out_row),
		.last       (last),
		.size_error (size_error)
	);

endmodule
`default_nettype wire
